// ===== rtl/dday_pkg.sv =====
// Shared constants and calendar helpers for the date / day-number converter.
// Used by dday_alu and date_day_number_converter; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dday_pkg;

    localparam int          FirstYear     = 1970;
    localparam int          DaysPerYear   = 365;
    localparam int          BlockDays     = 1461;      // days in 1970..1973 and every later block
    localparam int          RecipShift    = 26;
    localparam logic [15:0] RecipMul      = 16'd45934; // ceil(2^26 / 1461)
    localparam logic [3:0]  MonthsPerYear = 4'd12;
    localparam int          AccWidth      = 16;

    // Length of a month, 1-based; codes outside 1..12 read as 31
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        begin
            n = 5'd31;
            if (m == 4'd2)
            begin
                n = leap ? 5'd29 : 5'd28;
            end
            else if (m inside {4'd4, 4'd6, 4'd9, 4'd11})
            begin
                n = 5'd30;
            end
            return n;
        end
    endfunction

    // Length of a year: every fourth year is a leap year
    function automatic logic [8:0] year_len(input logic leap);
        return leap ? 9'd366 : 9'd365;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dday_alu.sv =====
// Shared add / subtract-and-compare unit for the converter sequencer.
// Depends on dday_pkg for the accumulator width.
`timescale 1ns / 1ps
`default_nettype none

module dday_alu
(
    input  wire logic [dday_pkg::AccWidth-1:0] a,
    input  wire logic [dday_pkg::AccWidth-1:0] b,
    input  wire logic                          sub,
    output logic      [dday_pkg::AccWidth-1:0] result,
    output logic                               gt
);
    import dday_pkg::*;

    logic [AccWidth:0]   sum;
    logic [AccWidth-1:0] b_mod;

    // Add, or subtract as a + ~b + 1
    assign b_mod  = sub ? ~b : b;
    assign sum    = {1'b0, a} + {1'b0, b_mod} + {{AccWidth{1'b0}}, sub};
    assign result = sum[AccWidth-1:0];

    // No borrow and a nonzero difference means a > b
    assign gt = sub && sum[AccWidth] && (result != '0);

endmodule

`default_nettype wire

// ===== rtl/date_day_number_converter.sv =====
// Date / day-number converter: operation 0 turns a date (1970..LAST_YEAR) into a day
// number where 1 January 1970 is day 1; operation 1 goes the other way. Every year
// divisible by four is a leap year. A word is taken when start is high and busy is low;
// the result appears for one cycle with done high and cannot be held off. A bad date or
// day number gives valid_res low with all fields zero. An invalid word is dropped in
// S_CHECK; operation 0 runs S_CHECK, S_D_LEAP, S_D_MON and S_D_DAY; operation 1 runs
// S_CHECK, S_N_QUO, S_N_MUL, S_N_SUB, then S_N_YEAR stepping up to 3 years within a
// four-year block and S_N_MON stepping up to 11 months. busy drops with done, so the
// next word can be taken at the edge that ends the result. The single shared
// add/subtract unit walks month lengths one per cycle; the four-year block is found by
// one reciprocal multiply.
// Depends on dday_pkg and dday_alu.
`timescale 1ns / 1ps
`default_nettype none

module date_day_number_converter
#(
    parameter int LAST_YEAR = 2099
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        operation,
    input  wire logic [4:0]  day,
    input  wire logic [3:0]  month,
    input  wire logic [11:0] year,
    input  wire logic [15:0] day_count,
    output logic             busy,
    output logic             done,
    output logic             valid_res,
    output logic [15:0]      out_day_count,
    output logic [4:0]       out_day,
    output logic [3:0]       out_month,
    output logic [11:0]      out_year
);
    import dday_pkg::*;

    localparam int LastDay = 365 * (LAST_YEAR - 1969) + (LAST_YEAR - 1968) / 4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_D_LEAP,
        S_D_MON,
        S_D_DAY,
        S_N_QUO,
        S_N_MUL,
        S_N_SUB,
        S_N_YEAR,
        S_N_MON
    } state_t;

    state_t        state_reg, state_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          valid_reg, valid_next;
    logic [15:0]   out_count_reg, out_count_next;
    logic [4:0]    out_day_reg, out_day_next;
    logic [3:0]    out_month_reg, out_month_next;
    logic [11:0]   out_year_reg, out_year_next;

    logic          op_reg, op_next;
    logic [4:0]    day_reg, day_next;
    logic [3:0]    month_reg, month_next;
    logic [11:0]   year_reg, year_next;
    logic [15:0]   cnt_reg, cnt_next;
    logic [15:0]   acc_reg, acc_next;
    logic [31:0]   prod_reg, prod_next;
    logic [5:0]    q_reg, q_next;
    logic [3:0]    mm_reg, mm_next;
    logic [11:0]   yy_reg, yy_next;

    logic [15:0]   alu_a, alu_b, alu_res;
    logic          alu_sub, alu_gt;

    logic [11:0]   year_off;
    logic [7:0]    k8;
    logic [6:0]    leap_cnt;
    logic          date_leap, num_leap;
    logic [15:0]   cnt_m1;
    logic          date_ok, num_ok;

    dday_alu u_alu
    (
        .a      (alu_a),
        .b      (alu_b),
        .sub    (alu_sub),
        .result (alu_res),
        .gt     (alu_gt)
    );

    // Decode the latched word
    assign year_off  = year_reg - 12'(FirstYear);
    assign k8        = year_off[7:0];
    assign leap_cnt  = 7'((9'(k8) + 9'd1) >> 2);
    assign date_leap = (year_reg[1:0] == 2'b00);
    assign num_leap  = (yy_reg[1:0] == 2'b00);
    assign cnt_m1    = cnt_reg - 16'd1;

    assign date_ok = (year_reg >= 12'(FirstYear)) && (year_reg <= 12'(LAST_YEAR))
                  && (month_reg >= 4'd1) && (month_reg <= MonthsPerYear)
                  && (day_reg >= 5'd1) && (day_reg <= month_len(month_reg, date_leap));
    assign num_ok  = (cnt_reg >= 16'd1) && (cnt_reg <= 16'(LastDay));

    // Sequencer: pick the shared unit's operands and the next values
    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        done_next      = 1'b0;
        valid_next     = valid_reg;
        out_count_next = out_count_reg;
        out_day_next   = out_day_reg;
        out_month_next = out_month_reg;
        out_year_next  = out_year_reg;
        op_next        = op_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        q_next         = q_reg;
        mm_next        = mm_reg;
        yy_next        = yy_reg;
        alu_a          = acc_reg;
        alu_b          = '0;
        alu_sub        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                // Take a word
                if (start)
                begin
                    op_next    = operation;
                    day_next   = day;
                    month_next = month;
                    year_next  = year;
                    cnt_next   = day_count;
                    busy_next  = 1'b1;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if ((!op_reg && !date_ok) || (op_reg && !num_ok))
                begin
                    // Drop an out-of-range word with a cleared result
                    done_next      = 1'b1;
                    busy_next      = 1'b0;
                    valid_next     = 1'b0;
                    out_count_next = '0;
                    out_day_next   = '0;
                    out_month_next = '0;
                    out_year_next  = '0;
                    state_next     = S_IDLE;
                end
                else if (!op_reg)
                begin
                    // Days of the whole years before this one at 365 each; leap days follow
                    acc_next   = 16'({8'b0, k8} * 16'(DaysPerYear));
                    mm_next    = 4'd1;
                    state_next = S_D_LEAP;
                end
                else
                begin
                    // Four-year block index by reciprocal multiply
                    prod_next  = {16'b0, cnt_m1} * {16'b0, RecipMul};
                    acc_next   = cnt_reg;
                    state_next = S_N_QUO;
                end
            end

            S_D_LEAP:
            begin
                alu_b      = {9'b0, leap_cnt};
                acc_next   = alu_res;
                state_next = S_D_MON;
            end

            S_D_MON:
            begin
                // Add the lengths of the months before this one
                if (mm_reg < month_reg)
                begin
                    alu_b    = {11'b0, month_len(mm_reg, date_leap)};
                    acc_next = alu_res;
                    mm_next  = mm_reg + 4'd1;
                end
                else
                begin
                    state_next = S_D_DAY;
                end
            end

            S_D_DAY:
            begin
                alu_b          = {11'b0, day_reg};
                done_next      = 1'b1;
                busy_next      = 1'b0;
                valid_next     = 1'b1;
                out_count_next = alu_res;
                out_day_next   = '0;
                out_month_next = '0;
                out_year_next  = '0;
                state_next     = S_IDLE;
            end

            S_N_QUO:
            begin
                q_next     = prod_reg[RecipShift+5:RecipShift];
                yy_next    = 12'(FirstYear) + {4'b0, prod_reg[RecipShift+5:RecipShift], 2'b00};
                state_next = S_N_MUL;
            end

            S_N_MUL:
            begin
                prod_next  = 32'({10'b0, q_reg} * 16'(BlockDays));
                state_next = S_N_SUB;
            end

            S_N_SUB:
            begin
                // Day within the four-year block, 1-based
                alu_b      = prod_reg[15:0];
                alu_sub    = 1'b1;
                acc_next   = alu_res;
                state_next = S_N_YEAR;
            end

            S_N_YEAR:
            begin
                // Step whole years inside the block
                alu_b   = {7'b0, year_len(num_leap)};
                alu_sub = 1'b1;
                if (alu_gt)
                begin
                    acc_next = alu_res;
                    yy_next  = yy_reg + 12'd1;
                end
                else
                begin
                    mm_next    = 4'd1;
                    state_next = S_N_MON;
                end
            end

            S_N_MON:
            begin
                // Step whole months, then report
                alu_b   = {11'b0, month_len(mm_reg, num_leap)};
                alu_sub = 1'b1;
                if ((mm_reg != MonthsPerYear) && alu_gt)
                begin
                    acc_next = alu_res;
                    mm_next  = mm_reg + 4'd1;
                end
                else
                begin
                    done_next      = 1'b1;
                    busy_next      = 1'b0;
                    valid_next     = 1'b1;
                    out_count_next = '0;
                    out_day_next   = acc_reg[4:0];
                    out_month_next = mm_reg;
                    out_year_next  = yy_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    // Hold state and the registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            valid_reg     <= 1'b0;
            out_count_reg <= '0;
            out_day_reg   <= '0;
            out_month_reg <= '0;
            out_year_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            done_reg      <= done_next;
            valid_reg     <= valid_next;
            out_count_reg <= out_count_next;
            out_day_reg   <= out_day_next;
            out_month_reg <= out_month_next;
            out_year_reg  <= out_year_next;
        end
    end

    // Advance the working registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        cnt_reg   <= cnt_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        q_reg     <= q_next;
        mm_reg    <= mm_next;
        yy_reg    <= yy_next;
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign valid_res     = valid_reg;
    assign out_day_count = out_count_reg;
    assign out_day       = out_day_reg;
    assign out_month     = out_month_reg;
    assign out_year      = out_year_reg;

    // A finished word frees the block in the same cycle
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // A result only follows a word in flight
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a word in flight");

    // A rejected word reports all fields zero
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !valid_res) |-> (out_day_count == '0 && out_day == '0
                                  && out_month == '0 && out_year == '0))
        else $error("rejected word with nonzero fields");

    // A good result carries exactly one direction, month in range
    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        (done && valid_res) |-> (((out_day_count != '0) != (out_month != '0))
                                 && (out_month <= MonthsPerYear)))
        else $error("result direction mismatch");

endmodule

`default_nettype wire
